// ----- rtl/bba_pkg.sv -----
// Shared constants, types and helpers for the bitmap block allocator.
// Used by bba_scan and bitmap_block_allocator in rtl/; depends on nothing.
`timescale 1ns / 1ps

package bba_pkg;

  // Bitmap geometry. WORD_BITS must be a power of two.
  localparam int BLOCK_COUNT   = 4096;
  localparam int WORD_BITS     = 64;
  localparam int INDEX_W       = 12;
  localparam int INDEX_LIMIT   = 1 << INDEX_W;
  localparam int USABLE_BLOCKS = (BLOCK_COUNT < INDEX_LIMIT) ? BLOCK_COUNT : INDEX_LIMIT;
  localparam int WORD_COUNT    = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W         = $clog2(WORD_BITS);
  // Only words holding reachable blocks are searched
  localparam int SCAN_WORDS    = (USABLE_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int SCAN_CNT_W    = $clog2(SCAN_WORDS + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_AW-1:0]   word_addr_t;
  typedef logic [BIT_W-1:0]     bit_pos_t;
  typedef logic [INDEX_W-1:0]   block_idx_t;

  // Command and status codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_FREE    = 1'b1;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SET,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } state_t;

  // Result of the first-clear-bit search over one word
  typedef struct packed {
    logic     found;
    bit_pos_t pos;
  } scan_res_t;

  // Bits of a word that lie above the last reachable block read as used
  function automatic word_t spare_mask(input word_addr_t w);
    word_t m;
    m = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (int'(w) * WORD_BITS + b >= USABLE_BLOCKS) begin
        m[b] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

// ----- rtl/bba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/bba_scan.sv -----
// Find-first-clear-bit unit: lowest zero bit of one bitmap word.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_scan
  import bba_pkg::*;
(
  input  word_t     word,
  output scan_res_t res
);

  // priority encode from the top down so the lowest clear bit wins
  always_comb begin
    res.found = 1'b0;
    res.pos   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.found = 1'b1;
        res.pos   = BIT_W'(i);
      end
    end
  end

endmodule

// ----- rtl/bitmap_block_allocator.sv -----
// Top level of the bitmap block allocator: sequencer, word-valid bits and result register.
// Depends on bba_pkg, bba_ram and bba_scan.
//
//  channel | signals                          | direction | word
//  input   | in_valid, in_stall               | in / out  | command, block_index
//  output  | out_valid, out_stall             | out / in  | granted_block, status
//
// An allocate reads one bitmap word per cycle through the RAM read port and runs it
// through the find-first-clear unit; on a hit it sets the bit in S_SET, then loads the result in S_DONE.
// A free is a read-modify-write of one word (S_FREE_RD, S_FREE_WR); an out-of-range free goes to S_DONE.
// Reset clears the per-word valid bits at once; an unwritten word reads as all free.
// A finished word waits in the output register while the next input word is taken;
// a new result is held back only while that register is still stalled.
`timescale 1ns / 1ps

module bitmap_block_allocator
  import bba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  block_idx_t block_index,
  output logic       out_valid,
  input  logic       out_stall,
  output block_idx_t granted_block,
  output logic       status
);

  state_t state, state_next;

  // RAM port controls
  logic       rd_en, wr_en;
  word_addr_t rd_addr, wr_addr;
  word_t      wr_data, rd_data;

  // per-word valid bits and the one sampled with each read
  logic [WORD_COUNT-1:0] word_valid;
  logic                  rd_valid;

  // scan pipeline
  logic [SCAN_CNT_W-1:0] scan_word;
  logic                  scan_issue;
  logic                  chk_ok;
  word_addr_t            chk_word;
  word_t                 chk_eff;
  word_t                 rd_eff;
  scan_res_t             scan_res;

  // work registers
  word_addr_t work_word;
  bit_pos_t   work_bit;
  word_t      work_data;
  block_idx_t res_granted;
  logic       res_status;

  logic in_fire, free_in_range, load_out, scan_hit, scan_miss;

  assign in_fire       = in_valid && !in_stall;
  assign free_in_range = int'(block_index) < BLOCK_COUNT;
  assign rd_eff        = rd_valid ? rd_data : '0;
  assign chk_eff       = rd_eff | spare_mask(chk_word);
  assign scan_issue    = (state == S_SCAN) && (scan_word < SCAN_CNT_W'(SCAN_WORDS));
  assign scan_hit      = chk_ok && scan_res.found;
  assign scan_miss     = chk_ok && !scan_res.found && (chk_word == WORD_AW'(SCAN_WORDS - 1));

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bba_scan u_scan (
    .word (chk_eff),
    .res  (scan_res)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (command == CMD_ALLOC) begin
            state_next = S_SCAN;
          end else if (free_in_range) begin
            state_next = S_FREE_RD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_next = S_SET;
        end else if (scan_miss) begin
          state_next = S_DONE;
        end
      end
      S_SET:     state_next = S_DONE;
      S_FREE_RD: state_next = S_FREE_WR;
      S_FREE_WR: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = work_word;
    wr_data  = '0;
    load_out = 1'b0;
    unique case (state)
      S_IDLE: in_stall = 1'b0;
      S_SCAN: begin
        rd_en   = scan_issue;
        rd_addr = scan_word[WORD_AW-1:0];
      end
      S_SET: begin
        wr_en   = 1'b1;
        wr_data = work_data | (word_t'(1) << work_bit);
      end
      S_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = work_word;
      end
      S_FREE_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_eff & ~(word_t'(1) << work_bit);
      end
      S_DONE:  load_out = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_valid <= '0;
      chk_ok     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      chk_ok <= scan_issue;
      if (wr_en) begin
        word_valid[wr_addr] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan address counter and read tracking
  always_ff @(posedge clk) begin
    if (in_fire) begin
      scan_word <= '0;
    end else if (scan_issue) begin
      scan_word <= scan_word + 1'b1;
    end
    if (rd_en) begin
      rd_valid <= word_valid[rd_addr];
    end
    chk_word <= scan_word[WORD_AW-1:0];
  end

  // work and result registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      work_word   <= word_addr_t'(block_index >> BIT_W);
      work_bit    <= block_index[BIT_W-1:0];
      res_granted <= '0;
      res_status  <= STATUS_DONE;
    end
    if (state == S_SCAN) begin
      if (scan_hit) begin
        work_word   <= chk_word;
        work_bit    <= scan_res.pos;
        work_data   <= chk_eff;
        res_granted <= INDEX_W'({chk_word, scan_res.pos});
      end else if (scan_miss) begin
        res_status  <= STATUS_FULL;
      end
    end
    if (load_out) begin
      granted_block <= res_granted;
      status        <= res_status;
    end
  end

endmodule
